@@ rtl/core/fbfl_pkg.sv @@
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared types and constants for the fixed-size block free-list allocator:
// request and status codes, field widths and the statistics event bundle.
// ----------------------------------------------------------------------------
package fbfl_pkg;

    // Field widths of the request, result and configuration transfers.
    localparam int REQ_W   = 2;
    localparam int IDX_W   = 8;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 16;
    localparam int TOT_W   = 32;
    localparam int CFG_W   = 9;

    // Built pool capacity and the block count loaded at hardware reset.
    localparam int DEF_MAX_BLOCKS  = 256;
    localparam int BLOCK_COUNT_RST = 256;

    // Request kinds.
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESET = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd2;

    // Events that move the usage statistics, at most one per committed request.
    typedef struct packed {
        logic alloc_ok;
        logic free_ok;
        logic pool_reset;
    } fbfl_evt_t;

endpackage

@@ rtl/core/fbfl_ram.sv @@
// ----------------------------------------------------------------------------
// fbfl_ram
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read port. Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module fbfl_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Storage array write.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/fbfl_stats.sv @@
// ----------------------------------------------------------------------------
// fbfl_stats
// Usage statistics: saturating used and peak counts and wrapping totals of
// successful allocations and accepted frees.
// ----------------------------------------------------------------------------
module fbfl_stats (
    input  logic                      clk,
    input  logic                      rst_n,
    input  fbfl_pkg::fbfl_evt_t       evt,
    output logic [fbfl_pkg::CNT_W-1:0] used_count,
    output logic [fbfl_pkg::CNT_W-1:0] peak_used,
    output logic [fbfl_pkg::TOT_W-1:0] total_allocs,
    output logic [fbfl_pkg::TOT_W-1:0] total_frees
);

    logic [fbfl_pkg::CNT_W-1:0] used_reg,   used_next;
    logic [fbfl_pkg::CNT_W-1:0] peak_reg,   peak_next;
    logic [fbfl_pkg::TOT_W-1:0] allocs_reg, allocs_next;
    logic [fbfl_pkg::TOT_W-1:0] frees_reg,  frees_next;
    logic [fbfl_pkg::CNT_W-1:0] used_inc;

    // Saturating increment of the used count, shared by the peak update.
    assign used_inc = (&used_reg) ? used_reg : used_reg + 1'b1;

    // Next values for each event kind.
    always_comb
    begin
        used_next   = used_reg;
        peak_next   = peak_reg;
        allocs_next = allocs_reg;
        frees_next  = frees_reg;
        if (evt.alloc_ok)
        begin
            used_next   = used_inc;
            peak_next   = (used_inc > peak_reg) ? used_inc : peak_reg;
            allocs_next = allocs_reg + 1'b1;
        end
        else if (evt.free_ok)
        begin
            used_next  = (used_reg != '0) ? used_reg - 1'b1 : used_reg;
            frees_next = frees_reg + 1'b1;
        end
        else if (evt.pool_reset)
        begin
            used_next = '0;
        end
    end

    // Statistics registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= '0;
            peak_reg   <= '0;
            allocs_reg <= '0;
            frees_reg  <= '0;
        end
        else
        begin
            used_reg   <= used_next;
            peak_reg   <= peak_next;
            allocs_reg <= allocs_next;
            frees_reg  <= frees_next;
        end
    end

    assign used_count   = used_reg;
    assign peak_used    = peak_reg;
    assign total_allocs = allocs_reg;
    assign total_frees  = frees_reg;

endmodule

@@ rtl/core/fixed_block_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// Timing: a taken request moves to the commit state, and its result is
// registered once the output is free; no new request is taken until it
// commits, paced by the registered read of the head's next link. A
// reset-pool request returns its result first; requests then wait for a
// rebuild sweep of every configured block. Hardware reset clears all
// control state and sweeps min(256, MAX_BLOCKS) blocks ahead of any request.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// Block index allocator over a last-in-first-out free list. The next links
// live in one synchronous RAM; the head, request and result are registers.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator #(
    parameter int MAX_BLOCKS = fbfl_pkg::DEF_MAX_BLOCKS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Configuration write channel.
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [fbfl_pkg::CFG_W-1:0]  cfg_data,
    // Request channel.
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [fbfl_pkg::REQ_W-1:0]  req_type,
    input  logic [fbfl_pkg::IDX_W-1:0]  block_index,
    // Result channel.
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [fbfl_pkg::STAT_W-1:0] status,
    output logic [fbfl_pkg::IDX_W-1:0]  granted_index,
    output logic [fbfl_pkg::CNT_W-1:0]  used_count,
    output logic [fbfl_pkg::CNT_W-1:0]  peak_used,
    output logic [fbfl_pkg::TOT_W-1:0]  total_allocs,
    output logic [fbfl_pkg::TOT_W-1:0]  total_frees
);

    // Address width, link width (holds the end mark) and block count width.
    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int LW = $clog2(MAX_BLOCKS + 1);
    localparam int EW = (LW > fbfl_pkg::CFG_W) ? LW : fbfl_pkg::CFG_W;
    localparam int RST_COUNT = (fbfl_pkg::BLOCK_COUNT_RST < MAX_BLOCKS) ?
                               fbfl_pkg::BLOCK_COUNT_RST : MAX_BLOCKS;

    localparam logic [LW-1:0] LINK_END = LW'(MAX_BLOCKS);
    localparam logic [EW-1:0] EFF_MAX  = EW'(MAX_BLOCKS);
    localparam logic [AW-1:0] RST_LAST = AW'(RST_COUNT - 1);

    // Controller states.
    localparam logic [1:0] S_SWEEP  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [LW-1:0]                head_reg, head_next;
    logic [AW-1:0]                sweep_ptr_reg, sweep_ptr_next;
    logic [AW-1:0]                sweep_last_reg, sweep_last_next;
    logic [fbfl_pkg::CFG_W-1:0]   block_count_reg;
    logic                         out_valid_reg, out_valid_next;
    logic [fbfl_pkg::STAT_W-1:0]  status_reg, status_next;
    logic [fbfl_pkg::IDX_W-1:0]   granted_reg, granted_next;
    logic [fbfl_pkg::REQ_W-1:0]   req_type_reg;
    logic [fbfl_pkg::IDX_W-1:0]   req_idx_reg;

    logic [EW-1:0]                count_ext;
    logic [EW-1:0]                eff_count;
    logic                         commit;
    logic                         head_ok;
    logic                         idx_ok;
    fbfl_pkg::fbfl_evt_t          evt;

    logic                         mem_wr_en;
    logic [AW-1:0]                mem_wr_addr;
    logic [LW-1:0]                mem_wr_data;
    logic                         mem_rd_en;
    logic [LW-1:0]                mem_rd_data;

    // Effective block count: the register clamped to 1..MAX_BLOCKS.
    assign count_ext = EW'(block_count_reg);
    assign eff_count = (count_ext == '0)     ? EW'(1)  :
                       (count_ext > EFF_MAX) ? EFF_MAX : count_ext;

    // Handshakes and conditions for the request in flight.
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign commit    = (state_reg == S_COMMIT) && (!out_valid_reg || out_ready);
    assign head_ok   = (head_reg < LINK_END);
    assign idx_ok    = (EW'(req_idx_reg) < eff_count);

    // The head's link is fetched as the request is taken.
    assign mem_rd_en = in_valid && in_ready && (req_type == fbfl_pkg::REQ_ALLOC);

    // Controller, head pointer, rebuild sweep and result selection.
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        sweep_ptr_next  = sweep_ptr_reg;
        sweep_last_next = sweep_last_reg;
        status_next     = status_reg;
        granted_next    = granted_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        evt             = '0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = sweep_ptr_reg;
        mem_wr_data     = (sweep_ptr_reg == sweep_last_reg) ?
                          LINK_END : LW'(sweep_ptr_reg) + LW'(1);

        unique case (state_reg)
            S_SWEEP:
            begin
                mem_wr_en      = 1'b1;
                sweep_ptr_next = sweep_ptr_reg + 1'b1;
                if (sweep_ptr_reg == sweep_last_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (commit)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = fbfl_pkg::STAT_OK;
                    granted_next   = '0;
                    unique case (req_type_reg)
                        fbfl_pkg::REQ_ALLOC:
                        begin
                            if (head_ok)
                            begin
                                granted_next = fbfl_pkg::IDX_W'(head_reg);
                                head_next    = mem_rd_data;
                                evt.alloc_ok = 1'b1;
                            end
                            else
                            begin
                                status_next = fbfl_pkg::STAT_EXHAUSTED;
                            end
                        end
                        fbfl_pkg::REQ_FREE:
                        begin
                            if (idx_ok)
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = AW'(req_idx_reg);
                                mem_wr_data = head_reg;
                                head_next   = LW'(req_idx_reg);
                                evt.free_ok = 1'b1;
                            end
                            else
                            begin
                                status_next = fbfl_pkg::STAT_RANGE;
                            end
                        end
                        fbfl_pkg::REQ_RESET:
                        begin
                            // Result goes out now; the chain is rebuilt after.
                            head_next       = '0;
                            sweep_ptr_next  = '0;
                            sweep_last_next = AW'(eff_count - EW'(1));
                            evt.pool_reset  = 1'b1;
                            state_next      = S_SWEEP;
                        end
                        fbfl_pkg::REQ_NONE:
                        begin
                            status_next = fbfl_pkg::STAT_OK;
                        end
                        default:
                        begin
                            status_next = fbfl_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_SWEEP;
            head_reg        <= '0;
            sweep_ptr_reg   <= '0;
            sweep_last_reg  <= RST_LAST;
            out_valid_reg   <= 1'b0;
            block_count_reg <= fbfl_pkg::CFG_W'(fbfl_pkg::BLOCK_COUNT_RST);
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            sweep_ptr_reg  <= sweep_ptr_next;
            sweep_last_reg <= sweep_last_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                block_count_reg <= cfg_data;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_type_reg <= req_type;
            req_idx_reg  <= block_index;
        end
        status_reg  <= status_next;
        granted_reg <= granted_next;
    end

    // Next-link memory.
    fbfl_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (head_reg[AW-1:0]),
        .rd_data (mem_rd_data)
    );

    // Usage statistics.
    fbfl_stats u_stats (
        .clk          (clk),
        .rst_n        (rst_n),
        .evt          (evt),
        .used_count   (used_count),
        .peak_used    (peak_used),
        .total_allocs (total_allocs),
        .total_frees  (total_frees)
    );

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign granted_index = granted_reg;

`ifndef SYNTH
    // The head is always a block index or the end mark.
    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= LINK_END)
        else $error("free list head beyond the end mark");

    // A taken request always moves to commit and blocks the next one.
    a_accept_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_COMMIT) && !in_ready)
        else $error("request transfer not followed by commit");

    // A link write never coincides with a link fetch.
    a_mem_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr_en && mem_rd_en))
        else $error("link write and link read in the same cycle");

    // Every commit presents a result on the next cycle.
    a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid)
        else $error("commit without a result");
`endif

endmodule
